@@ rtl/psno_pkg.sv @@
// ----------------------------------------------------------------------------
// psno_pkg
// Shared types and constants for the pulse/saw/noise oscillator.
// ----------------------------------------------------------------------------
package psno_pkg;

    typedef enum logic [1:0] {
        MODE_SILENT = 2'd0,
        MODE_SQUARE = 2'd1,
        MODE_SAW    = 2'd2,
        MODE_NOISE  = 2'd3
    } wave_mode_t;

    typedef enum logic [2:0] {
        REG_WAVE_MODE     = 3'd0,
        REG_OCTAVE_SHIFT  = 3'd1,
        REG_FINE_TUNE     = 3'd2,
        REG_BASE_PW       = 3'd3,
        REG_MOD_DEPTH     = 3'd4,
        REG_HOLD_SECONDS  = 3'd5,
        REG_SAMPLE_RATE   = 3'd6
    } reg_idx_t;

    localparam int CFG_DATA_W = 18;

    localparam logic [23:0] DEFAULT_PITCH = 24'd28160;   // 110 Hz in Q16.8
    localparam logic [15:0] FULL_POS      = 16'sd32767;
    localparam logic [15:0] FULL_NEG      = 16'h8001;    // -32767
    localparam logic [15:0] NEG_FULL_OFS  = 16'd32769;   // adds -32767 mod 2^16
    localparam logic [31:0] LFSR_SEED     = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;
    localparam logic [14:0] NOISE_MOD     = 15'd32767;
    localparam logic [15:0] SAW_SPAN      = 16'd65534;
    localparam logic [28:0] W_MAX         = 29'h1000_0000;

    function automatic logic [31:0] lfsr_step(input logic [31:0] l);
        lfsr_step = (l >> 1) ^ (l[0] ? LFSR_TAPS : 32'd0);
    endfunction

endpackage

@@ rtl/psno_tick_if.sv @@
// ----------------------------------------------------------------------------
// psno_tick_if
// Input tick channel: pitch and control values for one sample.
// ----------------------------------------------------------------------------
interface psno_tick_if;
    logic               valid;
    logic               ready;
    logic               pitch_present;
    logic [23:0]        pitch_hz;
    logic signed [15:0] width_cv;
    logic signed [15:0] hold_cv;

    modport source (output valid, output pitch_present, output pitch_hz,
                    output width_cv, output hold_cv, input ready);
    modport sink   (input valid, input pitch_present, input pitch_hz,
                    input width_cv, input hold_cv, output ready);
endinterface

@@ rtl/psno_cfg_if.sv @@
// ----------------------------------------------------------------------------
// psno_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface psno_cfg_if;
    import psno_pkg::*;
    logic                  valid;
    logic                  ready;
    reg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/psno_smp_if.sv @@
// ----------------------------------------------------------------------------
// psno_smp_if
// Output sample channel.
// ----------------------------------------------------------------------------
interface psno_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/psno_mul.sv @@
// ----------------------------------------------------------------------------
// psno_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module psno_mul #(
    parameter int AW = 32,
    parameter int BW = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0] a_reg;
    logic [PW-1:0] p_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [AW:0]   sum;

    assign sum = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            p_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                p_reg    <= {{AW{1'b0}}, b};
                cnt_reg  <= CW'(BW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                p_reg   <= {sum, p_reg[BW-1:1]};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

@@ rtl/psno_div.sv @@
// ----------------------------------------------------------------------------
// psno_div
// Restoring divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module psno_div #(
    parameter int NW = 40,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                num_reg <= {num_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/pulse_saw_noise_oscillator_core.sv @@
// ----------------------------------------------------------------------------
// pulse_saw_noise_oscillator_core
// Square / saw / sample-and-hold noise oscillator, one sample per tick.
//
//   Port   Dir   Beat contents
//   tick   in    pitch_present, pitch_hz, width_cv, hold_cv
//   cfg    in    index, data (register write)
//   smp    out   sample_out
//
// Silent beats go straight to the output. Square runs the frequency multiply,
// the cycle-length divide and the width multiply; saw may add a ramp divide;
// noise runs at most the length multiply and one noise divide. Zero frequency skips
// the cycle-length divide; a non-positive modulated hold skips the length multiply.
// tick is taken only in idle; one finished sample may wait in the output
// register while the next beat is worked. Reset is asynchronous; cfg is
// always ready.
// ----------------------------------------------------------------------------
module pulse_saw_noise_oscillator_core #(
    parameter int COUNT_BITS = 24
) (
    input logic clk,
    input logic rst_n,
    psno_tick_if.sink  tick,
    psno_cfg_if.sink   cfg,
    psno_smp_if.source smp
);
    import psno_pkg::*;

    localparam int CB      = COUNT_BITS;
    localparam int MUL_AW  = 32;
    localparam int MUL_BW  = (COUNT_BITS > 18) ? COUNT_BITS : 18;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int DIV_NW  = (COUNT_BITS + 16 > 38) ? COUNT_BITS + 16 : 38;
    localparam int DIV_DW  = 48;
    localparam int LEN_W   = 23;
    localparam logic [CB-1:0] CNT_MASK = {CB{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SUM, S_FREQ, S_CYC, S_PWM, S_LEN,
        S_PHASE, S_WAVE, S_SAW, S_NOISE, S_OUT
    } state_t;

    // configuration
    wave_mode_t  wave_mode_reg;
    logic [4:0]  octave_reg;
    logic [15:0] fine_reg, bpw_reg, mod_reg, hold_reg;
    logic [17:0] sr_reg;

    state_t state_reg, state_next;
    logic [23:0]        pitch_reg, pitch_next;
    logic signed [15:0] wcv_reg, wcv_next, hcv_reg, hcv_next;
    logic signed [32:0] prod_reg, prod_next;
    logic [28:0]        w_reg, w_next;
    logic [CB-1:0]      cycle_reg, cycle_next;
    logic [CB:0]        pw_reg, pw_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CB-1:0]      phase_reg, phase_next;
    logic [15:0]        held_reg, held_next;
    logic [31:0]        lfsr_reg, lfsr_next;
    logic [15:0]        res_reg, res_next;
    logic               up_reg, up_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;

    logic                mul_start_reg, mul_start_next;
    logic [MUL_AW-1:0]   mul_a_reg, mul_a_next;
    logic [MUL_BW-1:0]   mul_b_reg, mul_b_next;
    logic                mul_done;
    logic [MUL_PW-1:0]   mul_p;

    logic                div_start_reg, div_start_next;
    logic [DIV_NW-1:0]   div_num_reg, div_num_next;
    logic [DIV_DW-1:0]   div_den_reg, div_den_next;
    logic                div_done;
    logic [DIV_NW-1:0]   div_q;
    logic [DIV_DW-1:0]   div_r;

    // combinational helpers
    logic signed [4:0]  oct_s, oct_sat;
    logic [3:0]         oct_mag;
    logic [DIV_DW-1:0]  f48;
    logic signed [33:0] base_sum;
    logic [CB-1:0]      cyc_sat;
    logic [CB:0]        pw_raw, cyc_p1;
    logic [CB-1:0]      ph_inc;
    logic [DIV_NW-1:0]  saw_up_num, saw_dn_num;
    logic [CB-1:0]      ph_minus_pw;

    psno_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start_reg), .a(mul_a_reg),
        .b(mul_b_reg), .done(mul_done), .p(mul_p)
    );

    psno_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .num(div_num_reg),
        .den(div_den_reg), .done(div_done), .quo(div_q), .rem(div_r)
    );

    assign tick.ready     = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign smp.valid      = out_valid_reg;
    assign smp.sample_out = out_data_reg;

    always_comb
    begin
        oct_s = $signed(octave_reg);
        if (oct_s > 5'sd8)
            oct_sat = 5'sd8;
        else if (oct_s < -5'sd8)
            oct_sat = -5'sd8;
        else
            oct_sat = oct_s;
        oct_mag = oct_sat[4] ? 4'(-oct_sat) : oct_sat[3:0];
        if (oct_sat[4])
            f48 = {8'd0, mul_p[39:0]} >> oct_mag;
        else
            f48 = {8'd0, mul_p[39:0]} << oct_mag;

        if (wave_mode_reg == MODE_NOISE)
            base_sum = $signed({3'd0, hold_reg, 15'd0}) + 34'(prod_reg);
        else
            base_sum = $signed({7'd0, bpw_reg, 11'd0}) + 34'(prod_reg);

        cyc_sat = (div_q[DIV_NW-1:CB] != '0) ? CNT_MASK : div_q[CB-1:0];
        pw_raw  = mul_p[27+CB:27];
        cyc_p1  = {1'b0, cycle_reg} + (CB+1)'(1);
        ph_inc  = phase_reg + CB'(1);

        ph_minus_pw = phase_reg - pw_reg[CB-1:0];
        saw_up_num  = (DIV_NW'(phase_reg) << 16) - (DIV_NW'(phase_reg) << 1);
        saw_dn_num  = (DIV_NW'(ph_minus_pw) << 16) - (DIV_NW'(ph_minus_pw) << 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        pitch_next     = pitch_reg;
        wcv_next       = wcv_reg;
        hcv_next       = hcv_reg;
        prod_next      = prod_reg;
        w_next         = w_reg;
        cycle_next     = cycle_reg;
        pw_next        = pw_reg;
        len_next       = len_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        lfsr_next      = lfsr_reg;
        res_next       = res_reg;
        up_next        = up_reg;
        out_valid_next = out_valid_reg && !smp.ready;
        out_data_next  = out_data_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    pitch_next = tick.pitch_present ? tick.pitch_hz : DEFAULT_PITCH;
                    wcv_next   = tick.width_cv;
                    hcv_next   = tick.hold_cv;
                    if (wave_mode_reg == MODE_SILENT)
                    begin
                        res_next   = 16'd0;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                prod_next  = ((wave_mode_reg == MODE_NOISE) ? hcv_reg : wcv_reg)
                             * $signed({1'b0, mod_reg});
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (wave_mode_reg == MODE_NOISE)
                begin
                    if (base_sum > 34'sd0)
                    begin
                        mul_a_next     = base_sum[31:0];
                        mul_b_next     = MUL_BW'(sr_reg);
                        mul_start_next = 1'b1;
                        state_next     = S_LEN;
                    end
                    else
                    begin
                        len_next   = '0;
                        state_next = S_PHASE;
                    end
                end
                else
                begin
                    if (base_sum < 34'sd0)
                        w_next = '0;
                    else if (base_sum > $signed({5'd0, W_MAX}))
                        w_next = W_MAX;
                    else
                        w_next = base_sum[28:0];
                    mul_a_next     = MUL_AW'(pitch_reg);
                    mul_b_next     = MUL_BW'(fine_reg);
                    mul_start_next = 1'b1;
                    state_next     = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (mul_done)
                begin
                    if (f48 == '0)
                    begin
                        cycle_next     = CNT_MASK;
                        mul_a_next     = MUL_AW'(w_reg);
                        mul_b_next     = MUL_BW'(CNT_MASK);
                        mul_start_next = 1'b1;
                        state_next     = S_PWM;
                    end
                    else
                    begin
                        div_num_next   = DIV_NW'({sr_reg, 20'd0});
                        div_den_next   = f48;
                        div_start_next = 1'b1;
                        state_next     = S_CYC;
                    end
                end
            end
            S_CYC:
            begin
                if (div_done)
                begin
                    cycle_next     = cyc_sat;
                    mul_a_next     = MUL_AW'(w_reg);
                    mul_b_next     = MUL_BW'(cyc_sat);
                    mul_start_next = 1'b1;
                    state_next     = S_PWM;
                end
            end
            S_PWM:
            begin
                if (mul_done)
                begin
                    pw_next    = (pw_raw > cyc_p1) ? cyc_p1 : pw_raw;
                    state_next = S_PHASE;
                end
            end
            S_LEN:
            begin
                if (mul_done)
                begin
                    len_next   = mul_p[27+LEN_W-1:27];
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                if (wave_mode_reg == MODE_NOISE)
                begin
                    if (33'(ph_inc) > 33'(len_reg))
                    begin
                        phase_next     = '0;
                        lfsr_next      = lfsr_step(lfsr_reg);
                        div_num_next   = DIV_NW'(lfsr_step(lfsr_reg));
                        div_den_next   = DIV_DW'(NOISE_MOD);
                        div_start_next = 1'b1;
                        state_next     = S_NOISE;
                    end
                    else
                    begin
                        phase_next = ph_inc;
                        res_next   = held_reg;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    phase_next = (ph_inc > cycle_reg) ? '0 : ph_inc;
                    state_next = S_WAVE;
                end
            end
            S_WAVE:
            begin
                if (wave_mode_reg == MODE_SQUARE)
                begin
                    res_next   = ({1'b0, phase_reg} < pw_reg) ? FULL_POS : FULL_NEG;
                    state_next = S_OUT;
                end
                else if ({1'b0, phase_reg} < pw_reg)
                begin
                    up_next        = 1'b1;
                    div_num_next   = saw_up_num;
                    div_den_next   = DIV_DW'(pw_reg);
                    div_start_next = 1'b1;
                    state_next     = S_SAW;
                end
                else if ({1'b0, cycle_reg} <= pw_reg)
                begin
                    res_next   = FULL_POS;
                    state_next = S_OUT;
                end
                else
                begin
                    up_next        = 1'b0;
                    div_num_next   = saw_dn_num;
                    div_den_next   = DIV_DW'(cycle_reg - pw_reg[CB-1:0]);
                    div_start_next = 1'b1;
                    state_next     = S_SAW;
                end
            end
            S_SAW:
            begin
                if (div_done)
                begin
                    res_next   = up_reg ? (div_q[15:0] + NEG_FULL_OFS)
                                        : (FULL_POS - div_q[15:0]);
                    state_next = S_OUT;
                end
            end
            S_NOISE:
            begin
                if (div_done)
                begin
                    held_next  = {div_r[14:0], 1'b0} + NEG_FULL_OFS;
                    res_next   = {div_r[14:0], 1'b0} + NEG_FULL_OFS;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || smp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg <= MODE_SQUARE;
            octave_reg    <= 5'd0;
            fine_reg      <= 16'd4096;
            bpw_reg       <= 16'd32768;
            mod_reg       <= 16'd4096;
            hold_reg      <= 16'd0;
            sr_reg        <= 18'd44100;
            state_reg     <= S_IDLE;
            pitch_reg     <= '0;
            wcv_reg       <= '0;
            hcv_reg       <= '0;
            prod_reg      <= '0;
            w_reg         <= '0;
            cycle_reg     <= '0;
            pw_reg        <= '0;
            len_reg       <= '0;
            phase_reg     <= '0;
            held_reg      <= '0;
            lfsr_reg      <= LFSR_SEED;
            res_reg       <= '0;
            up_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            mul_start_reg <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            div_start_reg <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WAVE_MODE:    wave_mode_reg <= wave_mode_t'(cfg.data[1:0]);
                    REG_OCTAVE_SHIFT: octave_reg    <= cfg.data[4:0];
                    REG_FINE_TUNE:    fine_reg      <= cfg.data[15:0];
                    REG_BASE_PW:      bpw_reg       <= cfg.data[15:0];
                    REG_MOD_DEPTH:    mod_reg       <= cfg.data[15:0];
                    REG_HOLD_SECONDS: hold_reg      <= cfg.data[15:0];
                    REG_SAMPLE_RATE:  sr_reg        <= cfg.data;
                    default:          ;
                endcase
            end
            state_reg     <= state_next;
            pitch_reg     <= pitch_next;
            wcv_reg       <= wcv_next;
            hcv_reg       <= hcv_next;
            prod_reg      <= prod_next;
            w_reg         <= w_next;
            cycle_reg     <= cycle_next;
            pw_reg        <= pw_next;
            len_reg       <= len_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            lfsr_reg      <= lfsr_next;
            res_reg       <= res_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            mul_start_reg <= mul_start_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            div_start_reg <= div_start_next;
            div_num_reg   <= div_num_next;
            div_den_reg   <= div_den_next;
        end
    end

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 32'd0)
        else $error("noise LFSR locked at zero");

    a_phase_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAVE) |-> ({1'b0, phase_reg} <= {1'b0, cycle_reg}))
        else $error("phase beyond cycle length");

    a_saw_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SAW && div_done) |-> (div_q <= DIV_NW'(SAW_SPAN)))
        else $error("saw quotient out of range");

endmodule
